/* src/euclidean_distance_engine_macros.svh */
// euclidean_distance_engine_macros.svh
// Assertion macros shared by the RTL files of the Euclidean distance engine.
// No other file is needed; the macros compile to nothing when SYNTH is defined.
`ifndef EUCLIDEAN_DISTANCE_ENGINE_MACROS_SVH
`define EUCLIDEAN_DISTANCE_ENGINE_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define EDE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be true outside reset.
`define EDE_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define EDE_ASSERT(label, clk, rst, prop, msg)
`define EDE_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

/* src/ede_pkg.sv */
// ede_pkg.sv
// Types and fixed constants of the Euclidean distance engine.
// Used by every module of the engine; depends on nothing.
`timescale 1ns / 1ps

package ede_pkg;

   localparam int COORD_W    = 16;
   localparam int MAG_W      = 16;
   localparam int SQUARE_W   = 32;
   localparam int SUM_W      = 44;
   localparam int DIST_W     = 22;
   localparam int COUNT_W    = 32;
   localparam int LENGTH_W   = 11;
   localparam int ORDER_W    = 4;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_ADDR_W = 1;

   // One root bit is resolved per step of the square root unit.
   localparam int ROOT_STEPS = DIST_W;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam int REM_W      = DIST_W + 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_VECTOR_LENGTH = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_NORM_ORDER    = 1'b1;

   localparam logic [LENGTH_W-1:0] VECTOR_LENGTH_RESET = 11'd2;
   localparam logic [ORDER_W-1:0]  NORM_ORDER_RESET    = 4'd2;
   localparam logic [ORDER_W-1:0]  NORM_ORDER_L2       = 4'd2;

   localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

   typedef struct packed {
      logic [SUM_W-1:0] square_sum;
      logic             norm_is_l2;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_ROOT,
      BACK_DONE
   } back_state_type;

endpackage

/* src/euclidean_distance_engine.sv */
// euclidean_distance_engine.sv
// Top level of the Euclidean distance engine: front end, job queue, back end.
// Depends on ede_pkg, ede_front, ede_job_fifo and ede_back.
`timescale 1ns / 1ps

// Each request carries one coordinate pair (signed Q8.8); after vector_length
// requests one response gives the L2 distance (unsigned Q14.8, rounded to
// nearest, zero when norm_order is not 2) and the saturating count of distances.
// Requests are taken one per cycle while req_stall is low; the squared differences
// pass a three-stage multiply-accumulate pipeline. Each finished vector then waits
// in a queue of QUEUE_DEPTH entries for the square root unit, which resolves one
// root bit per cycle and then holds its result until the output is free. Requests
// stall while every queue slot is held by a vector whose last request has been
// taken and which the square root unit has not yet taken.

module euclidean_distance_engine
   import ede_pkg::*;
#(
   parameter int MAX_DIMENSION = 1024,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_ADDR_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COORD_W-1:0]  req_coord_first,
   input  logic signed [COORD_W-1:0]  req_coord_second,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DIST_W-1:0]          rsp_distance,
   output logic [COUNT_W-1:0]         rsp_distances_done
);

   logic    job_push;
   logic    job_pop;
   logic    queue_empty;
   job_type job_in;
   job_type job_out;

   ede_front #(
      .MAX_DIMENSION (MAX_DIMENSION),
      .QUEUE_DEPTH   (QUEUE_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coord_first  (req_coord_first),
      .req_coord_second (req_coord_second),
      .job_push         (job_push),
      .job_data         (job_in),
      .job_pop          (job_pop)
   );

   ede_job_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_in),
      .pop      (job_pop),
      .pop_job  (job_out),
      .empty    (queue_empty)
   );

   ede_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (!queue_empty),
      .job_data           (job_out),
      .job_pop            (job_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_distance       (rsp_distance),
      .rsp_distances_done (rsp_distances_done)
   );

endmodule

/* src/ede_front.sv */
// ede_front.sv
// Front end: configuration registers, request intake and the squared-difference
// accumulator. Depends on ede_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "euclidean_distance_engine_macros.svh"

module ede_front
   import ede_pkg::*;
#(
   parameter int MAX_DIMENSION = 1024,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [CSR_ADDR_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_W-1:0]    req_coord_first,
   input  logic signed [COORD_W-1:0]    req_coord_second,
   output logic                         job_push,
   output job_type                      job_data,
   input  logic                         job_pop
);

   localparam int POS_W    = $clog2(MAX_DIMENSION);
   localparam int LEN_W    = $clog2(MAX_DIMENSION + 1);
   localparam int CMP_W    = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
   localparam int CREDIT_W = $clog2(QUEUE_DEPTH + 1);

   logic [LENGTH_W-1:0]   vector_length_ff, vector_length_in;
   logic [ORDER_W-1:0]    norm_order_ff, norm_order_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CREDIT_W-1:0]   credit_ff, credit_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_last_ff, s1_last_in;
   logic [MAG_W-1:0]      s1_mag_ff, s1_mag_in;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_last_ff, s2_last_in;
   logic [SQUARE_W-1:0]   s2_square_ff, s2_square_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;

   logic                  accept;
   logic                  last;
   logic [CMP_W-1:0]      len_wide;
   logic [LEN_W-1:0]      len;
   logic [LEN_W-1:0]      pos_next;
   logic signed [COORD_W:0] diff;
   logic [COORD_W:0]      diff_abs;
   logic [SUM_W-1:0]      sum_added;

   assign req_stall = (credit_ff == CREDIT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      vector_length_in = vector_length_ff;
      norm_order_in    = norm_order_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_VECTOR_LENGTH: vector_length_in = csr_write_data[LENGTH_W-1:0];
            CSR_NORM_ORDER:    norm_order_in    = csr_write_data[ORDER_W-1:0];
            default: ;
         endcase
      end
   end

   // A length of zero acts as one; lengths beyond the build limit are clamped.
   always_comb begin
      len_wide = CMP_W'(vector_length_ff);
      if (len_wide == '0) begin
         len_wide = CMP_W'(1);
      end else if (len_wide > CMP_W'(MAX_DIMENSION)) begin
         len_wide = CMP_W'(MAX_DIMENSION);
      end
      len      = len_wide[LEN_W-1:0];
      pos_next = LEN_W'(pos_ff) + LEN_W'(1);
      last     = (pos_next >= len);
   end

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = last ? '0 : pos_next[POS_W-1:0];
      end
      credit_in = credit_ff;
      if ((accept && last) && !job_pop) begin
         credit_in = credit_ff + CREDIT_W'(1);
      end else if (!(accept && last) && job_pop) begin
         credit_in = credit_ff - CREDIT_W'(1);
      end
   end

   always_comb begin
      diff       = $signed({req_coord_first[COORD_W-1], req_coord_first})
                 - $signed({req_coord_second[COORD_W-1], req_coord_second});
      diff_abs   = diff[COORD_W] ? (COORD_W + 1)'(-diff) : (COORD_W + 1)'(diff);
      s1_valid_in = accept;
      s1_last_in  = last;
      s1_mag_in   = diff_abs[MAG_W-1:0];

      s2_valid_in  = s1_valid_ff;
      s2_last_in   = s1_last_ff;
      s2_square_in = s1_mag_ff * s1_mag_ff;

      sum_added = sum_ff + SUM_W'(s2_square_ff);
      job_push  = s2_valid_ff && s2_last_ff;
      job_data.square_sum = sum_added;
      job_data.norm_is_l2 = (norm_order_ff == NORM_ORDER_L2);
      sum_in = sum_ff;
      if (job_push) begin
         sum_in = '0;
      end else if (s2_valid_ff) begin
         sum_in = sum_added;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= VECTOR_LENGTH_RESET;
         norm_order_ff    <= NORM_ORDER_RESET;
         pos_ff           <= '0;
         credit_ff        <= '0;
         s1_valid_ff      <= 1'b0;
         s2_valid_ff      <= 1'b0;
         sum_ff           <= '0;
      end else begin
         vector_length_ff <= vector_length_in;
         norm_order_ff    <= norm_order_in;
         pos_ff           <= pos_in;
         credit_ff        <= credit_in;
         s1_valid_ff      <= s1_valid_in;
         s2_valid_ff      <= s2_valid_in;
         sum_ff           <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff   <= s1_last_in;
      s1_mag_ff    <= s1_mag_in;
      s2_last_ff   <= s2_last_in;
      s2_square_ff <= s2_square_in;
   end

   // Every finished vector holds a queue slot from intake until the back end takes it.
   `EDE_ASSERT(a_credit_bound, clock, reset, credit_ff <= CREDIT_W'(QUEUE_DEPTH), "credit overflow")

endmodule

/* src/ede_job_fifo.sv */
// ede_job_fifo.sv
// Short queue of finished square sums between the front and back ends.
// Depends on ede_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "euclidean_distance_engine_macros.svh"

module ede_job_fifo
   import ede_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               full;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == COUNT_W'(DEPTH));
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `EDE_ASSERT_NEVER(a_no_overflow, clock, reset, push && full && !pop, "push into full queue")

endmodule

/* src/ede_back.sv */
// ede_back.sv
// Back end: bit-serial square root with round to nearest, distance counter
// and the result register. Depends on ede_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "euclidean_distance_engine_macros.svh"

module ede_back
   import ede_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  job_type             job_data,
   output logic                job_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DIST_W-1:0]   rsp_distance,
   output logic [COUNT_W-1:0]  rsp_distances_done
);

   back_state_type       state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [SUM_W-1:0]     radicand_ff, radicand_in;
   logic [DIST_W-1:0]    root_ff, root_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic                 norm_ok_ff, norm_ok_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]    rsp_distance_ff, rsp_distance_in;
   logic [COUNT_W-1:0]   rsp_done_ff, rsp_done_in;

   logic [REM_W+1:0]     rem_shift;
   logic [REM_W+1:0]     trial;
   logic                 out_free;
   logic                 round_up;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distance       = rsp_distance_ff;
   assign rsp_distances_done = rsp_done_ff;
   assign out_free           = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      radicand_in     = radicand_ff;
      root_in         = root_ff;
      rem_in          = rem_ff;
      norm_ok_in      = norm_ok_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_distance_in = rsp_distance_ff;
      rsp_done_in     = rsp_done_ff;
      job_pop         = 1'b0;

      // Bring down the next two radicand bits and try the next root bit.
      rem_shift = {rem_ff, radicand_ff[SUM_W-1 -: 2]};
      trial     = (REM_W + 2)'({root_ff, 2'b01});
      round_up  = (rem_ff > REM_W'(root_ff));

      unique case (state_ff)
         BACK_IDLE: begin
            if (job_valid) begin
               job_pop     = 1'b1;
               radicand_in = job_data.square_sum;
               norm_ok_in  = job_data.norm_is_l2;
               root_in     = '0;
               rem_in      = '0;
               step_in     = '0;
               state_in    = BACK_ROOT;
            end
         end
         BACK_ROOT: begin
            radicand_in = radicand_ff << 2;
            if (rem_shift >= trial) begin
               rem_in  = REM_W'(rem_shift - trial);
               root_in = {root_ff[DIST_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift[REM_W-1:0];
               root_in = {root_ff[DIST_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            // The remainder is the radicand minus the root squared.
            if (out_free) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               rsp_valid_in    = 1'b1;
               rsp_done_in     = count_in;
               rsp_distance_in = norm_ok_ff ? root_ff + DIST_W'(round_up) : '0;
               state_in        = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      radicand_ff     <= radicand_in;
      root_ff         <= root_in;
      rem_ff          <= rem_in;
      norm_ok_ff      <= norm_ok_in;
      rsp_distance_ff <= rsp_distance_in;
      rsp_done_ff     <= rsp_done_in;
   end

   `EDE_ASSERT(a_pop_idle, clock, reset, job_pop |-> state_ff == BACK_IDLE, "pop outside idle")
   `EDE_ASSERT(a_step_range, clock, reset, state_ff == BACK_ROOT |-> step_ff < STEP_W'(ROOT_STEPS), "root step out of range")
   `EDE_ASSERT(a_count_sticky, clock, reset, count_ff != '0 |=> count_ff != '0, "distance count went back to zero")

endmodule
